[rtl/ffea_pkg.sv]
// Shared types and constants for the first-fit extent allocator.
package ffea_pkg;

  localparam int FREE_SLOTS = 16;
  localparam int USED_SLOTS = 32;
  localparam int PAGE_BITS  = 12;
  localparam int ADDR_BITS  = 32;

  localparam int FI_W = $clog2(FREE_SLOTS);
  localparam int FC_W = $clog2(FREE_SLOTS + 1);
  localparam int UI_W = $clog2(USED_SLOTS);

  localparam int SPACE_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [32:0] SPACE_LIMIT = 33'(1) << SPACE_BITS;
  localparam logic [32:0] PAGE_MASK   = (33'(1) << PAGE_BITS) - 33'(1);

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_ALLOC  = 3'd1;
  localparam logic [2:0] ST_MAPPED     = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] req_bytes;
    logic [31:0] block_start;
    logic        still_mapped;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_start;
    logic [31:0] out_size;
  } out_item_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic        is_free;
    logic        mapped;
    logic        too_big;
    logic [31:0] req;
    logic [32:0] rounded;
    logic [31:0] start;
  } job_t;

endpackage

[rtl/ffea_front.sv]
// Front end: accepts items, rounds sizes and queues classified jobs.
module ffea_front import ffea_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     job_valid,
  input  logic     job_take,
  output job_t     job
);

  localparam int QD = 2;

  job_t       q [QD];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  job_t       j;
  logic [32:0] rnd;

  always_comb begin
    rnd = (33'(in_item.req_bytes) + PAGE_MASK) & ~PAGE_MASK;
    j.is_free = (in_item.cmd == CMD_FREE);
    j.mapped  = in_item.still_mapped;
    j.req     = in_item.req_bytes;
    j.rounded = rnd;
    j.too_big = rnd[32];
    j.start   = in_item.block_start;
  end

  assign full      = (cnt == 2'(QD));
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];

  always_ff @(posedge clk) begin
    if (push && !full) q[wp] <= j;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push && !full) wp <= wp + 1'b1;
      if (job_take) rp <= rp + 1'b1;
      cnt <= cnt + 2'(push && !full) - 2'(job_take);
    end
  end

endmodule

[rtl/ffea_back.sv]
// Back end: sequencer that scans and edits the free and used tables.
module ffea_back import ffea_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_take,
  input  job_t      job,
  output logic      res_valid,
  input  logic      res_take,
  output out_item_t res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_USCAN = 4'd1;
  localparam logic [3:0] S_FSCAN = 4'd2;
  localparam logic [3:0] S_ADEC  = 4'd3;
  localparam logic [3:0] S_FPRE  = 4'd4;
  localparam logic [3:0] S_FNXT  = 4'd5;
  localparam logic [3:0] S_FDEC  = 4'd6;
  localparam logic [3:0] S_REM   = 4'd7;
  localparam logic [3:0] S_INS   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_PRE2  = 4'd11;

  logic [3:0]  state;
  job_t        cur;
  logic [31:0] fs [FREE_SLOTS];
  // sizes and used starts carry bit 32: a merged extent or the space top can reach 2^32
  logic [32:0] fz [FREE_SLOTS];
  logic [32:0] us [USED_SLOTS];
  logic [31:0] uz [USED_SLOTS];
  logic [USED_SLOTS-1:0] uv;
  logic [FC_W-1:0] fcnt;
  logic [32:0] top;

  logic [UI_W:0]   ui;
  logic            uhit, ufree_ok;
  logic [UI_W-1:0] uhit_i, ufree_i;
  logic [FC_W-1:0] fi;
  logic            fhit;
  logic [FI_W-1:0] fhit_i;
  logic [32:0]     s, nz;
  logic [31:0]     ns;
  logic            eq, mb, ma;
  logic [FC_W-1:0] p, rem_i, ins_i;
  logic [31:0]     e_s;
  logic [32:0]     e_z;
  logic            rem2;
  out_item_t       r;

  assign job_take  = (state == S_IDLE) && job_valid;
  assign res_valid = (state == S_OUT);
  assign res       = r;

  // Sequencer that scans and edits the free and used tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fcnt <= '0; top <= '0; uv <= '0;
    end else begin
      case (state)
        S_IDLE: if (job_valid) begin
          cur <= job; ui <= '0; uhit <= 1'b0; ufree_ok <= 1'b0;
          fi <= '0; fhit <= 1'b0;
          if (job.is_free && job.mapped) begin
            r <= '{status: ST_MAPPED, out_start: 32'd0, out_size: 32'd0};
            state <= S_OUT;
          end else if (job.is_free) begin
            r <= '0; s <= {1'b0, job.start}; state <= S_USCAN;
          end else if (job.too_big) begin
            r <= '{status: ST_EXHAUSTED, out_start: 32'd0, out_size: 32'd0};
            state <= S_OUT;
          end else begin
            r <= '0; state <= S_FSCAN;
          end
        end
        // allocate: first fit scan over live free entries
        S_FSCAN: begin
          if (!fhit && fi < fcnt && FI_W'(fi) < FREE_SLOTS
              && fz[FI_W'(fi)] > cur.req) begin
            fhit <= 1'b1; fhit_i <= FI_W'(fi);
          end
          if (fhit || fi >= fcnt) begin
            s <= fhit ? {1'b0, fs[fhit_i]} : top;
            state <= S_USCAN;
          end else fi <= fi + 1'b1;
        end
        // used-table scan: find start match and first empty slot
        S_USCAN: begin
          if (ui == (UI_W+1)'(USED_SLOTS)) begin
            state <= cur.is_free ? S_FPRE : S_ADEC;
            p <= '0;
          end else begin
            if (uv[UI_W'(ui)] && us[UI_W'(ui)] == s && !uhit) begin
              uhit <= 1'b1; uhit_i <= UI_W'(ui);
            end
            if (!uv[UI_W'(ui)] && !ufree_ok) begin
              ufree_ok <= 1'b1; ufree_i <= UI_W'(ui);
            end
            ui <= ui + 1'b1;
          end
        end
        S_ADEC: begin
          if (!uhit && !ufree_ok) begin
            r.status <= ST_TABLE_FULL; state <= S_OUT;
          end else if (fhit) begin
            if (cur.rounded >= fz[fhit_i]) begin
              rem_i <= FC_W'(fhit_i); rem2 <= 1'b0; state <= S_REM;
            end else begin
              fz[fhit_i] <= fz[fhit_i] - cur.rounded;
              fs[fhit_i] <= fs[fhit_i] + cur.rounded[31:0];
              state <= S_DONE;
            end
          end else if (top + cur.rounded > SPACE_LIMIT) begin
            r.status <= ST_EXHAUSTED; state <= S_OUT;
          end else begin
            top <= top + cur.rounded; state <= S_DONE;
          end
        end
        S_DONE: begin
          if (cur.is_free) begin
            uv[uhit_i] <= 1'b0;
          end else begin
            us[uhit ? uhit_i : ufree_i] <= s;
            uz[uhit ? uhit_i : ufree_i] <= cur.rounded[31:0];
            uv[uhit ? uhit_i : ufree_i] <= 1'b1;
            r <= '{status: ST_OK, out_start: s[31:0], out_size: cur.rounded[31:0]};
          end
          state <= S_OUT;
        end
        // free: locate insertion point
        S_FPRE: begin
          if (!uhit) begin
            r.status <= ST_NOT_ALLOC; state <= S_OUT;
          end else if (p < fcnt && fs[FI_W'(p)] < s) p <= p + 1'b1;
          else begin
            nz <= {1'b0, uz[uhit_i]};
            eq <= p < fcnt && fs[FI_W'(p)] == s;
            mb <= p != '0 && fs[FI_W'(p - 1'b1)] + fz[FI_W'(p - 1'b1)] == s;
            state <= S_PRE2;
          end
        end
        S_PRE2: begin
          ns <= mb ? fs[FI_W'(p - 1'b1)] : s[31:0];
          if (mb) nz <= nz + fz[FI_W'(p - 1'b1)];
          state <= S_FNXT;
        end
        S_FNXT: begin
          ins_i <= eq ? p + 1'b1 : p;
          ma <= (eq ? p + 1'b1 : p) < fcnt
                && ns + nz == fs[FI_W'(eq ? p + 1'b1 : p)];
          state <= S_FDEC;
        end
        S_FDEC: begin
          if (!eq && !mb && !ma && fcnt >= FC_W'(FREE_SLOTS)) begin
            r.status <= ST_TABLE_FULL; state <= S_OUT;
          end else begin
            if (ma) nz <= nz + fz[FI_W'(ins_i)];
            e_s <= ns;
            e_z <= nz + (ma ? fz[FI_W'(ins_i)] : 33'd0);
            if (ma) begin
              rem_i <= ins_i; rem2 <= 1'b1; state <= S_REM;
            end else begin
              rem2 <= 1'b1; state <= S_INS; ins_i <= fcnt;
            end
          end
        end
        // shift entries down one slot per cycle to drop rem_i
        S_REM: begin
          if (rem_i + 1'b1 < fcnt) begin
            fs[FI_W'(rem_i)] <= fs[FI_W'(rem_i + 1'b1)];
            fz[FI_W'(rem_i)] <= fz[FI_W'(rem_i + 1'b1)];
            rem_i <= rem_i + 1'b1;
          end else begin
            fcnt <= fcnt - 1'b1;
            if (rem2) begin
              rem2 <= 1'b1; state <= S_INS; ins_i <= fcnt - 1'b1;
            end else state <= S_DONE;
          end
        end
        // free edit after any after-merge removal
        S_INS: begin
          if (mb) begin
            fz[FI_W'(p - 1'b1)] <= e_z;
            if (eq && rem2) begin
              rem_i <= p; rem2 <= 1'b0; state <= S_REM;
            end else state <= S_DONE;
          end else if (eq) begin
            fz[FI_W'(p)] <= e_z; state <= S_DONE;
          end else if (ins_i > p) begin
            fs[FI_W'(ins_i)] <= fs[FI_W'(ins_i - 1'b1)];
            fz[FI_W'(ins_i)] <= fz[FI_W'(ins_i - 1'b1)];
            ins_i <= ins_i - 1'b1;
          end else begin
            fs[FI_W'(p)] <= e_s; fz[FI_W'(p)] <= e_z;
            fcnt <= fcnt + 1'b1; state <= S_DONE;
          end
        end
        S_OUT: if (res_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/first_fit_extent_allocator_core.sv]
// Top level of the first-fit extent allocator.
// Manages a 32-bit byte space in 4 KiB pages. Items come in on a queue-like
// port (push/full): cmd 0 allocates req_bytes rounded up to a page, taking
// the first free extent strictly larger than the request or else growing the
// top of the space; cmd 1 frees the block at block_start and coalesces it
// with its free neighbours. One result per item leaves through empty/pop
// with status, start and size.
// A two-entry job queue parts the front end from the sequencer in the back,
// so up to two more items are taken while the back is busy.
// Items that reach the tables take a full scan of the used table plus a
// scan or shift of free-table entries, one entry at a time.
// The result is held on the output until popped; the sequencer waits there
// and the front queue fills, raising full.
// Reset (rst, synchronous) empties both tables and zeroes the space top.
module first_fit_extent_allocator_core import ffea_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic job_valid, job_take, res_valid;
  job_t job;

  ffea_front u_front (
    .clk, .rst, .push, .full, .in_item,
    .job_valid, .job_take, .job
  );

  ffea_back u_back (
    .clk, .rst, .job_valid, .job_take, .job,
    .res_valid, .res_take(pop && res_valid), .res(out_item)
  );

  assign empty = !res_valid;

endmodule

[tb/first_fit_extent_allocator_core_tb.sv]
// Testbench for the first-fit extent allocator core: self-checking queue-port driver and monitor.
`timescale 1ns / 100ps

module first_fit_extent_allocator_core_tb import ffea_pkg::*;;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  first_fit_extent_allocator_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // predictor state
  logic [32:0] ext_start [FREE_SLOTS];
  logic [32:0] ext_size  [FREE_SLOTS];
  int          ext_count;
  logic [32:0] blk_start [USED_SLOTS];
  logic [32:0] blk_size  [USED_SLOTS];
  logic        blk_live  [USED_SLOTS];
  logic [32:0] top_of_space;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors = 0;
  int        n_results = 0;
  int        n_status[5] = '{default: 0};

  int   burst_left = 0, gap_left = 0;
  int   stall_phase = 0, hold_cycles = 0;

  function automatic int find_block(logic [32:0] s);
    for (int i = 0; i < USED_SLOTS; i++)
      if (blk_live[i] && blk_start[i] == s) return i;
    return -1;
  endfunction

  function automatic void drop_extent(int p);
    for (int i = p; i + 1 < ext_count; i++) begin
      ext_start[i] = ext_start[i + 1];
      ext_size[i]  = ext_size[i + 1];
    end
    ext_count--;
  endfunction

  function automatic out_item_t allocate_extent(logic [31:0] req);
    out_item_t   r;
    logic [32:0] rounded;
    logic [32:0] s;
    int          hit, slot;
    r = '0;
    rounded = ({1'b0, req} + PAGE_MASK) & ~PAGE_MASK;
    // rounding overflow past 32 bits
    if (({1'b0, req} + PAGE_MASK) >> 32 != 0 && rounded[32]) begin
      r.status = ST_EXHAUSTED;
      return r;
    end
    hit = -1;
    for (int i = 0; i < ext_count; i++)
      if (ext_size[i] > {1'b0, req}) begin
        hit = i;
        break;
      end
    s = (hit >= 0) ? ext_start[hit] : top_of_space;
    slot = find_block(s);
    if (slot < 0)
      for (int i = 0; i < USED_SLOTS; i++)
        if (!blk_live[i]) begin
          slot = i;
          break;
        end
    if (slot < 0) begin
      r.status = ST_TABLE_FULL;
      return r;
    end
    if (hit >= 0) begin
      if (rounded >= ext_size[hit]) drop_extent(hit);
      else begin
        ext_size[hit]  -= rounded;
        ext_start[hit] += rounded;
      end
    end else begin
      if (top_of_space + rounded > SPACE_LIMIT) begin
        r.status = ST_EXHAUSTED;
        return r;
      end
      top_of_space += rounded;
    end
    blk_start[slot] = s;
    blk_size[slot]  = rounded;
    blk_live[slot]  = 1'b1;
    r.status    = ST_OK;
    r.out_start = s[31:0];
    r.out_size  = rounded[31:0];
    return r;
  endfunction

  function automatic logic [2:0] release_block(logic [31:0] s, logic mapped);
    int          u, p, nxt;
    logic        equal, mb, ma;
    logic [32:0] ns, nz;
    if (mapped) return ST_MAPPED;
    u = find_block({1'b0, s});
    if (u < 0) return ST_NOT_ALLOC;
    nz = blk_size[u];
    p = 0;
    while (p < ext_count && ext_start[p] < {1'b0, s}) p++;
    equal = p < ext_count && ext_start[p] == {1'b0, s};
    mb = p > 0 && ext_start[p - 1] + ext_size[p - 1] == {1'b0, s};
    ns = mb ? ext_start[p - 1] : {1'b0, s};
    if (mb) nz += ext_size[p - 1];
    nxt = equal ? p + 1 : p;
    ma = nxt < ext_count && ns + nz == ext_start[nxt];
    if (!equal && !mb && !ma && ext_count >= FREE_SLOTS) return ST_TABLE_FULL;
    if (ma) nz += ext_size[nxt];
    blk_live[u] = 1'b0;
    if (ma) drop_extent(nxt);
    if (mb) begin
      ext_size[p - 1] = nz;
      if (equal) drop_extent(p);
    end else if (equal) begin
      ext_size[p] = nz;
    end else begin
      for (int i = ext_count; i > p; i--) begin
        ext_start[i] = ext_start[i - 1];
        ext_size[i]  = ext_size[i - 1];
      end
      ext_start[p] = ns;
      ext_size[p]  = nz;
      ext_count++;
    end
    return ST_OK;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.cmd == CMD_FREE) r.status = release_block(it.block_start, it.still_mapped);
    else r = allocate_extent(it.req_bytes);
    return r;
  endfunction

  // driver: bursts and gaps, falling edge
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      in_item <= '0;
    end else begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items[0];
        push <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // accept at the rising edge; the driver only looks at the queue head afterwards
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      expected_results.push_back(predict_result(in_item));
      void'(pending_items.pop_front());
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase == 400) begin
        hold_cycles <= 600;
        pop <= 1'b0;
      end else if ((stall_phase / 64) % 3 == 0) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 3) != 0) && (stall_phase % 5 != 2);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation: status %0d start %h size %h",
               out_item.status, out_item.out_start, out_item.out_size);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_results++;
        if (exp_r.status <= ST_EXHAUSTED) n_status[exp_r.status]++;
        if (out_item.status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_item.status);
          errors++;
        end
        if (out_item.out_start !== exp_r.out_start) begin
          $error("out_start: expected %h actual %h", exp_r.out_start, out_item.out_start);
          errors++;
        end
        if (out_item.out_size !== exp_r.out_size) begin
          $error("out_size: expected %h actual %h", exp_r.out_size, out_item.out_size);
          errors++;
        end
      end
    end
  end

  // stimulus shadow: starts of blocks likely live, to aim frees at real blocks
  logic [31:0] known_starts[$];

  function automatic in_item_t make_alloc(logic [31:0] bytes);
    in_item_t it;
    it = '0;
    it.cmd = CMD_ALLOC;
    it.req_bytes = bytes;
    it.block_start = $urandom;
    it.still_mapped = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic in_item_t make_free(logic [31:0] s, logic mapped);
    in_item_t it;
    it.cmd = CMD_FREE;
    it.req_bytes = $urandom;
    it.block_start = s;
    it.still_mapped = mapped;
    return it;
  endfunction

  function automatic logic [31:0] random_bytes();
    case ($urandom_range(0, 9))
      0: return 32'(0);
      1: return $urandom;
      2: return 32'($urandom_range(1, 4096));
      3: return 32'($urandom_range(0, 3)) << 12;
      default: return 32'($urandom_range(1, 40000));
    endcase
  endfunction

  initial begin
    logic [31:0] s;
    int          k;
    rst = 1'b1;
    ext_count = 0;
    top_of_space = '0;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      ext_start[i] = '0;
      ext_size[i] = '0;
    end
    for (int i = 0; i < USED_SLOTS; i++) begin
      blk_start[i] = '0;
      blk_size[i] = '0;
      blk_live[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: free on empty, zero byte, exact page, page+1, frees and merges
    pending_items.push_back(make_free(32'h0, 1'b0));
    pending_items.push_back(make_free(32'hFFFF_FFFF, 1'b1));
    pending_items.push_back(make_alloc(32'd0));
    pending_items.push_back(make_alloc(32'd0));
    pending_items.push_back(make_alloc(32'd4096));
    pending_items.push_back(make_alloc(32'd4097));
    pending_items.push_back(make_alloc(32'd1));
    pending_items.push_back(make_alloc(32'd8192));
    pending_items.push_back(make_free(32'h0000_1000, 1'b1));
    pending_items.push_back(make_free(32'h0000_1000, 1'b0));
    pending_items.push_back(make_free(32'h0000_4000, 1'b0));
    pending_items.push_back(make_free(32'h0000_3000, 1'b0));
    pending_items.push_back(make_free(32'h0000_3000, 1'b0));
    pending_items.push_back(make_alloc(32'd100));
    pending_items.push_back(make_alloc(32'd4096));
    pending_items.push_back(make_alloc(32'hFFFF_FFFF));
    pending_items.push_back(make_alloc(32'hFFFF_F001));
    pending_items.push_back(make_alloc(32'hFFF0_0000));
    pending_items.push_back(make_alloc(32'h8000_0000));
    pending_items.push_back(make_free(32'h0000_0000, 1'b0));
    pending_items.push_back(make_alloc(32'd1));
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    // directed items may exhaust the space; a reset is not allowed, so random
    // traffic runs mostly on frees/allocs recycled in the free table
    for (k = 0; k < 1900; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          pending_items.push_back(make_alloc(random_bytes()));
        end
        4, 5, 6, 7: begin
          if (known_starts.size() > 0 && $urandom_range(0, 4) != 0)
            s = known_starts[$urandom_range(0, known_starts.size() - 1)];
          else s = $urandom;
          pending_items.push_back(make_free(s, $urandom_range(0, 7) == 0));
        end
        default: begin
          s = 32'($urandom_range(0, 64)) << 12;
          pending_items.push_back(make_free(s, $urandom_range(0, 5) == 0));
        end
      endcase
      if (k % 50 == 49) begin
        wait (pending_items.size() == 0);
        // harvest starts the predictor holds as live
        known_starts.delete();
        for (int i = 0; i < USED_SLOTS; i++)
          if (blk_live[i]) known_starts.push_back(blk_start[i][31:0]);
      end
    end
    wait (pending_items.size() == 0);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("ran %0d results: ok %0d, not allocated %0d, mapped %0d",
             n_results, n_status[0], n_status[1], n_status[2]);
    $display("  table full %0d, space exhausted %0d", n_status[3], n_status[4]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
